// ----- design/sha256_stream_hasher_unit_assert.svh -----
// Assertion macros for the hasher; the sequencer module sha256_ctrl uses them.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge.
`define SHA256_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SHA256_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sha256_pkg.sv -----
package sha256_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_PAD,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic      shift_byte;
        byte_sel_t byte_sel;
        logic [2:0] len_idx;
        logic      count_inc;
        logic      load_work;
        logic      round_en;
        logic [5:0] round_idx;
        logic      update_h;
        logic      clear_msg;
        logic [2:0] word_idx;
    } ctrl_t;

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] ROUND_LAST    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// ----- design/sha256_ctrl.sv -----
`include "sha256_stream_hasher_unit_assert.svh"

module sha256_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic              out_free,
    output logic              out_load,
    output sha256_pkg::ctrl_t ctrl
);
    import sha256_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] fill_reg;
    logic [5:0] round_reg;
    logic [2:0] word_reg;
    logic       padding_reg;
    logic       len_phase_reg;
    logic       accept;
    logic       block_full;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign block_full = (fill_reg == LAST_POS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (block_full)
                        state_next = ST_ROUND;
                    else if (func == FUNC_FINISH)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!padding_reg)
                    state_next = ST_IDLE;
                else if (!len_phase_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && (word_reg == LAST_WORD_IDX))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall       = 1'b1;
        out_load       = 1'b0;
        ctrl           = '0;
        ctrl.byte_sel  = BYTE_ZERO;
        ctrl.len_idx   = fill_reg[2:0];
        ctrl.round_idx = round_reg;
        ctrl.word_idx  = word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall        = 1'b0;
                ctrl.shift_byte = accept;
                ctrl.byte_sel   = (func == FUNC_FINISH) ? BYTE_PAD : BYTE_DATA;
                ctrl.count_inc  = accept && (func == FUNC_ABSORB);
                ctrl.load_work  = accept && block_full;
            end
            ST_PAD:
            begin
                ctrl.shift_byte = 1'b1;
                ctrl.byte_sel   = (len_phase_reg && (fill_reg >= LEN_POS)) ? BYTE_LEN
                                                                           : BYTE_ZERO;
                ctrl.load_work  = block_full;
            end
            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
            end
            ST_UPDATE:
            begin
                ctrl.update_h = 1'b1;
            end
            ST_EMIT:
            begin
                out_load       = out_free;
                ctrl.clear_msg = out_free && (word_reg == LAST_WORD_IDX);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            round_reg     <= '0;
            word_reg      <= '0;
            padding_reg   <= 1'b0;
            len_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.shift_byte)
                fill_reg <= fill_reg + 6'd1;
            if (ctrl.round_en)
                round_reg <= round_reg + 6'd1;
            if (out_load)
                word_reg <= word_reg + 3'd1;
            if (accept && (func == FUNC_FINISH))
            begin
                padding_reg   <= 1'b1;
                // The length fits in this block only if the pad byte lands before it.
                len_phase_reg <= (fill_reg < LEN_POS);
            end
            else if ((state_reg == ST_UPDATE) && padding_reg)
                len_phase_reg <= 1'b1;
            else if (ctrl.clear_msg)
            begin
                padding_reg   <= 1'b0;
                len_phase_reg <= 1'b0;
            end
        end
    end

    `SHA256_ASSERT_NEXT(a_round_start, (state_reg != ST_ROUND) && (state_next == ST_ROUND), (fill_reg == 6'd0) && (round_reg == 6'd0), "compression started on a partial block")
    `SHA256_ASSERT(a_emit_final, (state_reg != ST_EMIT) || (padding_reg && len_phase_reg && (fill_reg == 6'd0)), "digest emitted before the length block")
    `SHA256_ASSERT_NEXT(a_emit_done, (state_reg == ST_EMIT) && out_free && (word_reg == LAST_WORD_IDX), (state_reg == ST_IDLE) && !padding_reg && (word_reg == 3'd0), "message state not cleared after digest")

endmodule

// ----- design/sha256_compress.sv -----
module sha256_compress (
    input  logic              clk,
    input  logic              rst_n,
    input  sha256_pkg::ctrl_t ctrl,
    input  logic [7:0]        data_byte,
    output logic [31:0]       hash_word
);
    import sha256_pkg::*;

    // The block buffer doubles as the rolling schedule window: word i sits
    // at bits [511-32*i -: 32], oldest word on top.
    logic [511:0] buf_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [63:0]  count_reg;

    logic [7:0]   byte_in;
    logic [31:0]  w_cur, w_m15, w_m7, w_m2, w_new;
    logic [31:0]  t1, t2;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        unique case (ctrl.byte_sel)
            BYTE_DATA: byte_in = data_byte;
            BYTE_PAD:  byte_in = PAD_BYTE;
            BYTE_ZERO: byte_in = 8'h00;
            BYTE_LEN:  byte_in = 8'(count_reg >> {~ctrl.len_idx, 3'b000});
        endcase
    end

    always_comb
    begin
        w_cur = buf_reg[511:480];
        w_m15 = buf_reg[479:448];
        w_m7  = buf_reg[223:192];
        w_m2  = buf_reg[63:32];
        w_new = w_cur + (ror(w_m15, 7) ^ ror(w_m15, 18) ^ (w_m15 >> 3)) + w_m7
              + (ror(w_m2, 17) ^ ror(w_m2, 19) ^ (w_m2 >> 10));
        t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_k(ctrl.round_idx) + w_cur;
        t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign hash_word = h_reg[ctrl.word_idx];

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_byte)
            buf_reg <= {buf_reg[503:0], byte_in};
        else if (ctrl.round_en)
            buf_reg <= {buf_reg[479:0], w_new};

        if (ctrl.load_work)
            v_reg <= h_reg;
        else if (ctrl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= H_INIT;
            count_reg <= '0;
        end
        else
        begin
            if (ctrl.update_h)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            else if (ctrl.clear_msg)
                h_reg <= H_INIT;

            if (ctrl.clear_msg)
                count_reg <= '0;
            else if (ctrl.count_inc)
                count_reg <= count_reg + 64'd8;
        end
    end

endmodule

// ----- design/sha256_stream_hasher_unit.sv -----
// Absorb word: the byte is shifted in; a byte that completes a 64-byte block also starts
// the compression. Finish word: the pad byte, then the remaining pad bytes, then the
// compression (64 rounds on the shared round unit plus one update), twice
// when the length needs an extra block, then eight digest words, one per output load.
// Reset loads the initial hash values and clears the byte fill and the bit count;
// the block buffer needs no clearing pass.
module sha256_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha256_pkg::*;

    // The sequencer walks the block through byte loading, padding, the 64
    // rounds and the chaining update. The datapath holds one round unit that
    // is reused for every round and a 512-bit shift line that serves both as
    // the byte buffer and as the sliding message schedule.
    ctrl_t       ctrl;
    logic        out_free;
    logic        out_load;
    logic [31:0] hash_word;

    logic        out_valid_reg;
    logic [31:0] digest_word_reg;
    logic [2:0]  word_index_reg;
    logic        last_word_reg;

    // The output register can take a new word when it is empty or its
    // current word is taken in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    sha256_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .out_free (out_free),
        .out_load (out_load),
        .ctrl     (ctrl)
    );

    sha256_compress u_compress (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .data_byte (data_byte),
        .hash_word (hash_word)
    );

    // Output register: the block may accept the next message byte while the
    // last digest word still waits here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            digest_word_reg <= hash_word;
            word_index_reg  <= ctrl.word_idx;
            last_word_reg   <= (ctrl.word_idx == LAST_WORD_IDX);
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_word_reg;
    assign word_index  = word_index_reg;
    assign last_word   = last_word_reg;

endmodule
